/* hdl/tcpq_pkg.sv */
// Package for the three-class priority queue with eviction.
// Holds command and class codes, the cell payload type and sizing constants.
`default_nettype none
package tcpq_pkg;
	localparam int DEPTH_DEF    = 128;
	localparam int CAP_RESET    = 100;

	typedef enum logic [1:0] {
		CMD_ENQ   = 2'd0,
		CMD_DEQ   = 2'd1,
		CMD_PEEK  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	localparam logic [1:0] CLS_NORMAL   = 2'd0;
	localparam logic [1:0] CLS_HIGH     = 2'd1;
	localparam logic [1:0] CLS_CRITICAL = 2'd2;

	localparam logic [3:0] REG_CAPACITY = 4'd0;

	typedef struct packed {
		logic [15:0] tag;
		logic [1:0]  cls;
		logic [7:0]  topic_len;
		logic [15:0] payload_len;
		logic [31:0] stamp;
	} entry_t;

	// Shift operation applied by every cell in the same cycle
	typedef enum logic [1:0] {
		SH_HOLD  = 2'd0,
		SH_INS   = 2'd1,
		SH_REM   = 2'd2
	} shift_op_t;

	typedef struct packed {
		shift_op_t op;
		logic      valid;
	} chain_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_EVICT = 2'd1,
		ST_APPLY = 2'd2,
		ST_OUT   = 2'd3
	} state_t;
endpackage
`default_nettype wire

/* hdl/tcpq_if.sv */
// Valid/ready channel interfaces for request and result items.
// Depends on nothing but the port widths of the queue.
`default_nettype none
interface tcpq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [1:0]  priority_req;
	logic [15:0] msg_tag;
	logic [7:0]  topic_len;
	logic [15:0] payload_len;
	logic [31:0] stamp;
	modport source (output valid, cmd, priority_req, msg_tag, topic_len, payload_len, stamp,
		input ready);
	modport sink (input valid, cmd, priority_req, msg_tag, topic_len, payload_len, stamp,
		output ready);
endinterface

interface tcpq_res_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [15:0] out_tag;
	logic [1:0]  out_priority;
	logic [7:0]  out_topic_len;
	logic [15:0] out_payload_len;
	logic [31:0] out_stamp;
	logic [7:0]  entry_count;
	logic        full_res;
	logic [23:0] byte_total;
	logic [31:0] drop_total;
	modport source (output valid, ok, out_tag, out_priority, out_topic_len, out_payload_len,
		out_stamp, entry_count, full_res, byte_total, drop_total, input ready);
	modport sink (input valid, ok, out_tag, out_priority, out_topic_len, out_payload_len,
		out_stamp, entry_count, full_res, byte_total, drop_total, output ready);
endinterface
`default_nettype wire

/* hdl/tcpq_cell.sv */
// One storage cell of the shifting queue chain.
// Depends on tcpq_pkg for the entry type and shift codes.
`default_nettype none
module tcpq_cell (
	input  wire logic            clk,
	input  wire tcpq_pkg::chain_ctl_t ctl,
	input  wire logic            ins_here,
	input  wire logic            ins_after,
	input  wire logic            rem_from,
	input  wire tcpq_pkg::entry_t new_entry,
	input  wire tcpq_pkg::entry_t prev_entry,
	input  wire tcpq_pkg::entry_t next_entry,
	output tcpq_pkg::entry_t     entry
);
	tcpq_pkg::entry_t entry_q;

	// Take new data, the left neighbor on insert, or the right neighbor on removal
	always_ff @(posedge clk) begin
		if (ctl.valid) begin
			case (ctl.op)
				tcpq_pkg::SH_INS: begin
					if (ins_here)       entry_q <= new_entry;
					else if (ins_after) entry_q <= prev_entry;
				end
				tcpq_pkg::SH_REM: begin
					if (rem_from) entry_q <= next_entry;
				end
				default: ;
			endcase
		end
	end

	assign entry = entry_q;
endmodule
`default_nettype wire

/* hdl/tcpq_chain.sv */
// Row of DEPTH cells with per-cell class match flags for position search.
// Depends on tcpq_pkg and tcpq_cell.
`default_nettype none
module tcpq_chain #(
	parameter int DEPTH = tcpq_pkg::DEPTH_DEF,
	parameter int IW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire tcpq_pkg::chain_ctl_t ctl,
	input  wire logic [IW-1:0]    pos,
	input  wire tcpq_pkg::entry_t new_entry,
	output tcpq_pkg::entry_t      front,
	output logic [DEPTH-1:0]      is_normal,
	output logic [DEPTH-1:0]      is_high,
	output logic [DEPTH-1:0]      is_crit,
	output logic [16:0]           bytes_at [DEPTH]
);
	tcpq_pkg::entry_t cells [DEPTH];

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			tcpq_pkg::entry_t prev_e, next_e;
			logic [IW-1:0] gi;
			assign gi     = IW'(g);
			assign prev_e = (g == 0) ? new_entry : cells[(g == 0) ? 0 : g-1];
			assign next_e = (g == DEPTH-1) ? cells[g] : cells[(g == DEPTH-1) ? g : g+1];
			tcpq_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.ins_here   (gi == pos),
				.ins_after  (gi > pos),
				.rem_from   (gi >= pos),
				.new_entry  (new_entry),
				.prev_entry (prev_e),
				.next_entry (next_e),
				.entry      (cells[g])
			);
			// Per-cell class flags feed the position search
			assign is_normal[g] = (cells[g].cls == tcpq_pkg::CLS_NORMAL);
			assign is_high[g]   = (cells[g].cls == tcpq_pkg::CLS_HIGH);
			assign is_crit[g]   = (cells[g].cls == tcpq_pkg::CLS_CRITICAL);
			assign bytes_at[g]  = 17'(cells[g].topic_len) + 17'(cells[g].payload_len);
		end
	endgenerate

	assign front = cells[0];
endmodule
`default_nettype wire

/* hdl/three_class_priority_queue_evict.sv */
// Three-class priority queue with eviction, top level.
// Each request passes through the evict and apply states before its result is
// registered and presented, for every command; one request in flight at a time.
// A new request is taken only after the previous result has been taken.
// Reset clears count, byte total, drop count and capacity (to 100); cell
// contents are undefined until written.
`default_nettype none
module three_class_priority_queue_evict #(
	parameter int DEPTH = tcpq_pkg::DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	tcpq_req_if.sink         req,
	tcpq_res_if.source       res,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	tcpq_pkg::state_t state_q, state_d;
	logic [7:0]                     cap_q;
	logic [CW-1:0]                  cnt_q, cnt_d;
	logic [23:0]                    bytes_q, bytes_d;
	logic [31:0]                    drops_q, drops_d;
	tcpq_pkg::entry_t               req_s1;
	logic [1:0]                     cmd_s1;
	tcpq_pkg::chain_ctl_t           ctl;
	logic [IW-1:0]                  pos;
	tcpq_pkg::entry_t               front;
	logic [DEPTH-1:0]               is_normal, is_high, is_crit;
	logic [16:0]                    bytes_at [DEPTH];
	logic                           ok_d;
	logic                           ok_q;
	tcpq_pkg::entry_t               out_q, out_d;
	logic                           res_valid_q;
	logic [IW-1:0]                  ev_pos_q;
	logic                           ev_any_q;
	logic [IW-1:0]                  hi_pos_q;

	// APB capacity register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {24'd0, cap_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cap_q <= 8'(tcpq_pkg::CAP_RESET);
		else if (psel && penable && pwrite && paddr[2:0] == {tcpq_pkg::REG_CAPACITY[0], 2'b00})
			cap_q <= pwdata[7:0];
	end

	// Effective limit
	logic [CW:0] limit;
	assign limit = ({1'b0, CW'(0)} | (CW+1)'(cap_q)) < (CW+1)'(DEPTH) ?
		(CW+1)'(cap_q) : (CW+1)'(DEPTH);

	// Search: first normal, last high, first non-critical, all within count
	logic [IW-1:0] first_norm, last_high, first_noncrit;
	logic          any_norm, any_high;
	always_comb begin
		first_norm    = '0;
		last_high     = '0;
		first_noncrit = IW'(cnt_q);
		any_norm      = 1'b0;
		any_high      = 1'b0;
		for (int i = DEPTH-1; i >= 0; i--) begin
			if (CW'(i) < cnt_q) begin
				if (is_normal[i]) begin
					first_norm = IW'(i);
					any_norm   = 1'b1;
				end
				if (!is_crit[i]) first_noncrit = IW'(i);
			end
		end
		for (int i = 0; i < DEPTH; i++) begin
			if (CW'(i) < cnt_q && is_high[i]) begin
				last_high = IW'(i);
				any_high  = 1'b1;
			end
		end
	end

	// Register the search results
	always_ff @(posedge clk) begin
		ev_pos_q <= any_norm ? first_norm : last_high;
		ev_any_q <= any_norm || any_high;
		hi_pos_q <= first_noncrit;
	end

	tcpq_chain #(.DEPTH(DEPTH), .IW(IW)) u_chain (
		.clk       (clk),
		.ctl       (ctl),
		.pos       (pos),
		.new_entry (req_s1),
		.front     (front),
		.is_normal (is_normal),
		.is_high   (is_high),
		.is_crit   (is_crit),
		.bytes_at  (bytes_at)
	);

	// Capture request
	assign req.ready = (state_q == tcpq_pkg::ST_IDLE);
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1             <= req.cmd;
			req_s1.tag         <= req.msg_tag;
			req_s1.cls         <= (req.priority_req == 2'd3) ? tcpq_pkg::CLS_NORMAL
				: req.priority_req;
			req_s1.topic_len   <= req.topic_len;
			req_s1.payload_len <= req.payload_len;
			req_s1.stamp       <= req.stamp;
		end
	end

	logic full_now;
	assign full_now = ((CW+1)'(cnt_q) >= limit);

	// Sequencer
	always_comb begin
		state_d  = state_q;
		ctl      = '{op: tcpq_pkg::SH_HOLD, valid: 1'b0};
		pos      = '0;
		cnt_d    = cnt_q;
		bytes_d  = bytes_q;
		drops_d  = drops_q;
		ok_d     = ok_q;
		out_d    = out_q;
		unique case (state_q)
			tcpq_pkg::ST_IDLE: begin
				if (req.valid) state_d = tcpq_pkg::ST_EVICT;
			end
			tcpq_pkg::ST_EVICT: begin
				state_d = tcpq_pkg::ST_APPLY;
				out_d   = '0;
				ok_d    = 1'b0;
				if (cmd_s1 == tcpq_pkg::CMD_ENQ && full_now &&
					req_s1.cls == tcpq_pkg::CLS_CRITICAL && ev_any_q) begin
					ctl     = '{op: tcpq_pkg::SH_REM, valid: 1'b1};
					pos     = ev_pos_q;
					cnt_d   = cnt_q - CW'(1);
					bytes_d = bytes_q - 24'(bytes_at[ev_pos_q]);
					if (drops_q != '1) drops_d = drops_q + 32'd1;
				end
			end
			tcpq_pkg::ST_APPLY: begin
				state_d = tcpq_pkg::ST_OUT;
				unique case (cmd_s1)
					tcpq_pkg::CMD_ENQ: begin
						if ((req_s1.cls != tcpq_pkg::CLS_CRITICAL && full_now) ||
							(CW'(DEPTH) == cnt_q)) begin
							if (drops_q != '1) drops_d = drops_q + 32'd1;
						end else begin
							ok_d  = 1'b1;
							ctl   = '{op: tcpq_pkg::SH_INS, valid: 1'b1};
							pos   = (req_s1.cls == tcpq_pkg::CLS_CRITICAL) ? '0 :
								(req_s1.cls == tcpq_pkg::CLS_HIGH) ? hi_pos_q : IW'(cnt_q);
							cnt_d = cnt_q + CW'(1);
							bytes_d = bytes_q + 24'(req_s1.topic_len) + 24'(req_s1.payload_len);
						end
					end
					tcpq_pkg::CMD_DEQ, tcpq_pkg::CMD_PEEK: begin
						if (cnt_q != '0) begin
							ok_d  = 1'b1;
							out_d = front;
							if (cmd_s1 == tcpq_pkg::CMD_DEQ) begin
								ctl     = '{op: tcpq_pkg::SH_REM, valid: 1'b1};
								pos     = '0;
								cnt_d   = cnt_q - CW'(1);
								bytes_d = bytes_q - 24'(bytes_at[0]);
							end
						end
					end
					tcpq_pkg::CMD_CLEAR: begin
						ok_d    = 1'b1;
						cnt_d   = '0;
						bytes_d = '0;
					end
					default: ;
				endcase
			end
			tcpq_pkg::ST_OUT: begin
				if (res.ready) state_d = tcpq_pkg::ST_IDLE;
			end
			default: state_d = tcpq_pkg::ST_IDLE;
		endcase
	end

	// State and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcpq_pkg::ST_IDLE;
			cnt_q   <= '0;
			bytes_q <= '0;
			drops_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			bytes_q <= bytes_d;
			drops_q <= drops_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid_q <= 1'b0;
		else if (state_q == tcpq_pkg::ST_APPLY) res_valid_q <= 1'b1;
		else if (res.ready) res_valid_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		ok_q  <= ok_d;
		out_q <= out_d;
	end

	assign res.valid           = res_valid_q;
	assign res.ok              = ok_q;
	assign res.out_tag         = out_q.tag;
	assign res.out_priority    = out_q.cls;
	assign res.out_topic_len   = out_q.topic_len;
	assign res.out_payload_len = out_q.payload_len;
	assign res.out_stamp       = out_q.stamp;
	assign res.entry_count     = 8'(cnt_q);
	assign res.full_res        = full_now;
	assign res.byte_total      = bytes_q;
	assign res.drop_total      = drops_q;
endmodule
`default_nettype wire

/* hdl/tcpq_checker.sv */
// Port-level checker for the priority queue, bound to the top level.
// Depends on the top level's ports and on tcpq_pkg for the default depth.
`default_nettype none
module tcpq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [7:0]  entry_count,
	input wire logic [31:0] drop_total
);
	// No request taken while a result waits
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> !in_ready)
		else $error("request accepted with result pending");
	// Result holds until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drop_total))
		else $error("result dropped");
	// Drop count never decreases between results
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> drop_total >= $past(drop_total))
		else $error("drop count decreased");
	// Count stays within the store
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= 8'(tcpq_pkg::DEPTH_DEF))
		else $error("count overflow");
endmodule

bind three_class_priority_queue_evict tcpq_checker u_tcpq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (req.valid),
	.in_ready    (req.ready),
	.out_valid   (res.valid),
	.out_ready   (res.ready),
	.entry_count (res.entry_count),
	.drop_total  (res.drop_total)
);
`default_nettype wire
